>>> design/cfde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfde_pkg
// Shared types and constants for the clipped framebuffer draw engine.
// ----------------------------------------------------------------------------
package cfde_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int FB_DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW       = $clog2(FB_DEPTH);
  localparam int XW       = $clog2(SCREEN_WIDTH);
  localparam int YW       = $clog2(SCREEN_HEIGHT);
  localparam int XW1      = $clog2(SCREEN_WIDTH + 1);
  localparam int YW1      = $clog2(SCREEN_HEIGHT + 1);
  localparam int PW       = 18;

  typedef enum logic [2:0] {
    FUNC_FILL       = 3'd0,
    FUNC_BMP_START  = 3'd1,
    FUNC_BMP_BYTE   = 3'd2,
    FUNC_LINE_START = 3'd3,
    FUNC_LINE_PIX   = 3'd4,
    FUNC_READ       = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    KIND_IDLE   = 2'd0,
    KIND_BITMAP = 2'd1,
    KIND_LINE   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [11:0]        width;
    logic [11:0]        height;
    logic [15:0]        fg_color;
    logic [15:0]        bg_color;
    logic [15:0]        data;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        on_screen;
  } out_beat_t;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    logic [15:0]   wdata;
  } fb_req_t;

  typedef struct packed {
    logic done;
    logic on;
  } rd_stat_t;

endpackage

>>> design/cfde_fb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfde_fb_ram
// Single-port framebuffer memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module cfde_fb_ram (
  input  logic             clk,
  input  cfde_pkg::fb_req_t req,
  output logic [15:0]      rdata
);

  logic [15:0] mem [cfde_pkg::FB_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

>>> design/cfde_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfde_seq
// Command sequencer: clear pass, clipping, stream state, pixel walk and reads.
// ----------------------------------------------------------------------------
module cfde_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cfde_pkg::in_beat_t  in_beat,
  input  logic                out_free,
  output cfde_pkg::fb_req_t   req,
  output cfde_pkg::rd_stat_t  rd_stat
);

  localparam int PW = cfde_pkg::PW;
  localparam int XW = cfde_pkg::XW;
  localparam int YW = cfde_pkg::YW;
  localparam int XW1 = cfde_pkg::XW1;
  localparam int YW1 = cfde_pkg::YW1;
  localparam int AW = cfde_pkg::AW;
  localparam logic signed [PW-1:0] SW_S = PW'(cfde_pkg::SCREEN_WIDTH);
  localparam logic signed [PW-1:0] SH_S = PW'(cfde_pkg::SCREEN_HEIGHT);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_FILL  = 7'b0000100,
    S_BITS  = 7'b0001000,
    S_PIX   = 7'b0010000,
    S_RDREQ = 7'b0100000,
    S_RDDAT = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  cfde_pkg::kind_t     kind_r, kind_nxt;
  logic signed [15:0]  base_x_r, base_x_nxt;
  logic signed [15:0]  base_y_r, base_y_nxt;
  logic [11:0]         span_w_r, span_w_nxt;
  logic [11:0]         span_h_r, span_h_nxt;
  logic [15:0]         fore_r, fore_nxt;
  logic [15:0]         back_r, back_nxt;
  logic [11:0]         row_r, row_nxt;
  logic [11:0]         col_r, col_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;

  logic [XW-1:0]       fx_r, fx_nxt;
  logic [XW-1:0]       fx0_r, fx0_nxt;
  logic [XW1-1:0]      fx1_r, fx1_nxt;
  logic [YW-1:0]       fy_r, fy_nxt;
  logic [YW1-1:0]      fy1_r, fy1_nxt;
  logic [11:0]         bcol_r, bcol_nxt;
  logic [11:0]         brow_r, brow_nxt;
  logic [2:0]          bit_r, bit_nxt;
  logic [15:0]         wdat_r, wdat_nxt;
  logic signed [15:0]  rx_r, rx_nxt;
  logic signed [15:0]  ry_r, ry_nxt;
  logic                rd_on_r, rd_on_nxt;

  logic                in_accept;
  logic signed [PW-1:0] xs, ys, xe, ye, x0, y0, x1, y1;
  logic                fill_ok;
  logic [12:0]         col_sum;
  logic [12:0]         bit_col;
  logic signed [PW-1:0] bx_s, by_s;
  logic signed [PW-1:0] plot_x, plot_y;
  logic                plot_en, plot_on;
  logic [15:0]         plot_data;
  logic [AW-1:0]       plot_addr;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  // rectangle clip
  always_comb begin
    xs = PW'(in_beat.x_pos);
    ys = PW'(in_beat.y_pos);
    xe = xs + $signed({{(PW-12){1'b0}}, in_beat.width});
    ye = ys + $signed({{(PW-12){1'b0}}, in_beat.height});
    x0 = (xs < 0) ? '0 : xs;
    y0 = (ys < 0) ? '0 : ys;
    x1 = (xe > SW_S) ? SW_S : xe;
    y1 = (ye > SH_S) ? SH_S : ye;
    fill_ok = (x0 < x1) && (y0 < y1);
  end

  assign col_sum = {1'b0, col_r} + 13'd8;
  assign bit_col = {1'b0, bcol_r} + {10'b0, bit_r};
  assign bx_s    = PW'(base_x_r);
  assign by_s    = PW'(base_y_r);

  // pixel position and data for the current cycle
  always_comb begin
    plot_x    = '0;
    plot_y    = '0;
    plot_en   = 1'b0;
    plot_data = wdat_r;
    unique case (state_r)
      S_FILL: begin
        plot_x  = $signed({{(PW-XW){1'b0}}, fx_r});
        plot_y  = $signed({{(PW-YW){1'b0}}, fy_r});
        plot_en = 1'b1;
      end
      S_BITS: begin
        plot_x    = bx_s + $signed({{(PW-13){1'b0}}, bit_col});
        plot_y    = by_s + $signed({{(PW-12){1'b0}}, brow_r});
        plot_en   = (bit_col < {1'b0, span_w_r});
        plot_data = wdat_r[{1'b0, ~bit_r}] ? fore_r : back_r;
      end
      S_PIX: begin
        plot_x  = bx_s + $signed({{(PW-12){1'b0}}, bcol_r});
        plot_y  = by_s;
        plot_en = 1'b1;
      end
      S_RDREQ: begin
        plot_x = PW'(rx_r);
        plot_y = PW'(ry_r);
      end
      S_CLEAR, S_IDLE, S_RDDAT: begin
      end
      default: begin
      end
    endcase
    plot_on   = (plot_x >= 0) && (plot_x < SW_S) && (plot_y >= 0) && (plot_y < SH_S);
    plot_addr = AW'({{(AW-YW){1'b0}}, plot_y[YW-1:0]} * AW'(cfde_pkg::SCREEN_WIDTH))
              + AW'(plot_x[XW-1:0]);
  end

  always_comb begin
    req.we    = 1'b0;
    req.re    = 1'b0;
    req.addr  = plot_addr;
    req.wdata = plot_data;
    if (state_r == S_CLEAR) begin
      req.we    = 1'b1;
      req.addr  = clr_r;
      req.wdata = '0;
    end else if (state_r == S_RDREQ) begin
      req.re = out_free && plot_on;
    end else begin
      req.we = plot_en && plot_on;
    end
  end

  assign rd_stat.done = (state_r == S_RDDAT);
  assign rd_stat.on   = rd_on_r;

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    base_x_nxt = base_x_r;
    base_y_nxt = base_y_r;
    span_w_nxt = span_w_r;
    span_h_nxt = span_h_r;
    fore_nxt   = fore_r;
    back_nxt   = back_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    clr_nxt    = clr_r;
    fx_nxt     = fx_r;
    fx0_nxt    = fx0_r;
    fx1_nxt    = fx1_r;
    fy_nxt     = fy_r;
    fy1_nxt    = fy1_r;
    bcol_nxt   = bcol_r;
    brow_nxt   = brow_r;
    bit_nxt    = bit_r;
    wdat_nxt   = wdat_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    rd_on_nxt  = rd_on_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(cfde_pkg::FB_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          unique case (in_beat.func)
            cfde_pkg::FUNC_FILL: begin
              if (fill_ok) begin
                fx_nxt    = x0[XW-1:0];
                fx0_nxt   = x0[XW-1:0];
                fx1_nxt   = x1[XW1-1:0];
                fy_nxt    = y0[YW-1:0];
                fy1_nxt   = y1[YW1-1:0];
                wdat_nxt  = in_beat.fg_color;
                state_nxt = S_FILL;
              end
            end
            cfde_pkg::FUNC_BMP_START: begin
              base_x_nxt = in_beat.x_pos;
              base_y_nxt = in_beat.y_pos;
              span_w_nxt = in_beat.width;
              span_h_nxt = in_beat.height;
              fore_nxt   = in_beat.fg_color;
              back_nxt   = in_beat.bg_color;
              kind_nxt   = cfde_pkg::KIND_BITMAP;
              row_nxt    = '0;
              col_nxt    = '0;
            end
            cfde_pkg::FUNC_BMP_BYTE: begin
              if (kind_r == cfde_pkg::KIND_BITMAP && span_w_r != '0 && row_r < span_h_r) begin
                bcol_nxt  = col_r;
                brow_nxt  = row_r;
                bit_nxt   = '0;
                wdat_nxt  = {8'h00, in_beat.data[7:0]};
                state_nxt = S_BITS;
                if (col_sum >= {1'b0, span_w_r}) begin
                  col_nxt = '0;
                  row_nxt = row_r + 12'd1;
                end else begin
                  col_nxt = col_sum[11:0];
                end
              end
            end
            cfde_pkg::FUNC_LINE_START: begin
              base_x_nxt = in_beat.x_pos;
              base_y_nxt = in_beat.y_pos;
              span_w_nxt = in_beat.width;
              kind_nxt   = cfde_pkg::KIND_LINE;
              row_nxt    = '0;
              col_nxt    = '0;
            end
            cfde_pkg::FUNC_LINE_PIX: begin
              if (kind_r == cfde_pkg::KIND_LINE && col_r < span_w_r) begin
                bcol_nxt  = col_r;
                wdat_nxt  = in_beat.data;
                col_nxt   = col_r + 12'd1;
                state_nxt = S_PIX;
              end
            end
            cfde_pkg::FUNC_READ: begin
              rx_nxt    = in_beat.x_pos;
              ry_nxt    = in_beat.y_pos;
              state_nxt = S_RDREQ;
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        if (XW1'(fx_r) + XW1'(1) == fx1_r) begin
          fx_nxt = fx0_r;
          if (YW1'(fy_r) + YW1'(1) == fy1_r) begin
            state_nxt = S_IDLE;
          end else begin
            fy_nxt = fy_r + YW'(1);
          end
        end else begin
          fx_nxt = fx_r + XW'(1);
        end
      end
      S_BITS: begin
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          state_nxt = S_IDLE;
        end
      end
      S_PIX: begin
        state_nxt = S_IDLE;
      end
      S_RDREQ: begin
        if (out_free) begin
          rd_on_nxt = plot_on;
          state_nxt = S_RDDAT;
        end
      end
      S_RDDAT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      kind_r   <= cfde_pkg::KIND_IDLE;
      base_x_r <= '0;
      base_y_r <= '0;
      span_w_r <= '0;
      span_h_r <= '0;
      fore_r   <= '0;
      back_r   <= '0;
      row_r    <= '0;
      col_r    <= '0;
      clr_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      kind_r   <= kind_nxt;
      base_x_r <= base_x_nxt;
      base_y_r <= base_y_nxt;
      span_w_r <= span_w_nxt;
      span_h_r <= span_h_nxt;
      fore_r   <= fore_nxt;
      back_r   <= back_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      clr_r    <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fx_r    <= fx_nxt;
    fx0_r   <= fx0_nxt;
    fx1_r   <= fx1_nxt;
    fy_r    <= fy_nxt;
    fy1_r   <= fy1_nxt;
    bcol_r  <= bcol_nxt;
    brow_r  <= brow_nxt;
    bit_r   <= bit_nxt;
    wdat_r  <= wdat_nxt;
    rx_r    <= rx_nxt;
    ry_r    <= ry_nxt;
    rd_on_r <= rd_on_nxt;
  end

endmodule

>>> design/clipped_framebuffer_draw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_framebuffer_draw_engine
// RGB565 framebuffer with clipped fill, bitmap, line and pixel read commands.
// ----------------------------------------------------------------------------
// Read: S_RDREQ waits for a free output, then S_RDDAT; out_valid is registered.
// Commands are taken only in idle; fill walks the clipped rectangle, a bitmap
//   byte its bits, a line pixel its pixel; one memory write or read per cycle.
// Reset: in_stall stays high while the framebuffer is cleared to zero, all
//   SCREEN_WIDTH*SCREEN_HEIGHT words in turn; stream state idle.
module clipped_framebuffer_draw_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cfde_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output cfde_pkg::out_beat_t out_beat
);

  cfde_pkg::fb_req_t   req;
  cfde_pkg::rd_stat_t  rd_stat;
  cfde_pkg::out_beat_t out_beat_r;
  logic [15:0]         rdata;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || !out_stall;

  cfde_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_free (out_free),
    .req      (req),
    .rd_stat  (rd_stat)
  );

  cfde_fb_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rd_stat.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_stat.done) begin
      out_beat_r.pixel_value <= rd_stat.on ? rdata : 16'h0000;
      out_beat_r.on_screen   <= rd_stat.on;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

>>> tb/sv/clipped_framebuffer_draw_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_framebuffer_draw_engine_test
// Self-checking bench for the clipped framebuffer draw engine. A directed
// table covers the screen edges, clipping, stream overruns, stray stream data
// and unused codes. Random command streams follow. Every read-back beat is
// compared with a behavioral framebuffer or a typed row's value. Both channels
// are paced at random, with one long output hold-off and one full drain.
// ----------------------------------------------------------------------------
module clipped_framebuffer_draw_engine_test;
  import cfde_pkg::*;

  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_READS   = 40;
  localparam int TAIL_CYCLES  = 16;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_mode_t;

  typedef struct {
    bit        typed;
    out_beat_t want;
  } read_key_t;

  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } table_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  clipped_framebuffer_draw_engine uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // behavioral framebuffer and stream state
  bit [15:0] fb_copy [FB_DEPTH];
  int        org_x = 0;
  int        org_y = 0;
  int        run_w = 0;
  int        run_h = 0;
  int        cur_row = 0;
  int        cur_col = 0;
  bit [15:0] fg_hold = '0;
  bit [15:0] bg_hold = '0;
  kind_t     open_kind = KIND_IDLE;

  out_beat_t  due_pixels [$];
  read_key_t  read_keys [$];
  table_row_t dir_table [$];

  int errors = 0;
  int sent = 0;
  int in_taken = 0;
  int burst_left = 0;
  int big_fills = 0;
  int hold_asks = 0;
  int hold_served = 0;

  function automatic void put_pixel(int px, int py, bit [15:0] c);
    if (px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT)
      fb_copy[py * SCREEN_WIDTH + px] = c;
  endfunction

  function automatic bit render_command(in_beat_t b, output out_beat_t r);
    int x, y, w, h, i, j;
    x = int'(b.x_pos);
    y = int'(b.y_pos);
    w = int'(b.width);
    h = int'(b.height);
    r = '0;
    render_command = 1'b0;
    case (b.func)
      FUNC_FILL: begin
        if (x < 0) begin
          w += x;
          x = 0;
        end
        if (y < 0) begin
          h += y;
          y = 0;
        end
        if (x + w > SCREEN_WIDTH) w = SCREEN_WIDTH - x;
        if (y + h > SCREEN_HEIGHT) h = SCREEN_HEIGHT - y;
        if (w > 0 && h > 0)
          for (j = y; j < y + h; j++)
            for (i = x; i < x + w; i++)
              fb_copy[j * SCREEN_WIDTH + i] = b.fg_color;
      end
      FUNC_BMP_START: begin
        org_x = x;
        org_y = y;
        run_w = w;
        run_h = h;
        fg_hold = b.fg_color;
        bg_hold = b.bg_color;
        open_kind = KIND_BITMAP;
        cur_row = 0;
        cur_col = 0;
      end
      FUNC_BMP_BYTE: begin
        if (open_kind == KIND_BITMAP && run_w != 0 && cur_row < run_h) begin
          for (i = 0; i < 8; i++)
            if (cur_col + i < run_w)
              put_pixel(org_x + cur_col + i, org_y + cur_row,
                        b.data[7 - i] ? fg_hold : bg_hold);
          cur_col += 8;
          if (cur_col >= run_w) begin
            cur_col = 0;
            cur_row++;
          end
        end
      end
      FUNC_LINE_START: begin
        org_x = x;
        org_y = y;
        run_w = w;
        open_kind = KIND_LINE;
        cur_row = 0;
        cur_col = 0;
      end
      FUNC_LINE_PIX: begin
        if (open_kind == KIND_LINE && cur_col < run_w) begin
          put_pixel(org_x + cur_col, org_y, b.data);
          cur_col++;
        end
      end
      FUNC_READ: begin
        render_command = 1'b1;
        if (x >= 0 && x < SCREEN_WIDTH && y >= 0 && y < SCREEN_HEIGHT) begin
          r.pixel_value = fb_copy[y * SCREEN_WIDTH + x];
          r.on_screen = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(logic [2:0] f, int x, int y, int w, int h, int fg,
                                  int bg, int d, bit typed = 1'b0, int pv = 0,
                                  bit on = 1'b0);
    table_row_t row;
    row.beat.func = f;
    row.beat.x_pos = 16'(x);
    row.beat.y_pos = 16'(y);
    row.beat.width = 12'(w);
    row.beat.height = 12'(h);
    row.beat.fg_color = 16'(fg);
    row.beat.bg_color = 16'(bg);
    row.beat.data = 16'(d);
    row.typed = typed;
    row.want.pixel_value = 16'(pv);
    row.want.on_screen = on;
    dir_table.push_back(row);
  endfunction

  function automatic int near_x();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, SCREEN_WIDTH + 39)) - 20;
  endfunction

  function automatic int near_y();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, SCREEN_HEIGHT + 39)) - 20;
  endfunction

  function automatic in_beat_t noise_beat();
    in_beat_t b;
    b.func = 3'($urandom_range(0, 7));
    b.x_pos = 16'($urandom_range(0, 65535));
    b.y_pos = 16'($urandom_range(0, 65535));
    b.width = 12'($urandom_range(0, 4095));
    b.height = 12'($urandom_range(0, 4095));
    b.fg_color = 16'($urandom_range(0, 65535));
    b.bg_color = 16'($urandom_range(0, 65535));
    b.data = 16'($urandom_range(0, 65535));
    return b;
  endfunction

  function automatic in_beat_t make_read();
    in_beat_t b;
    b = noise_beat();
    b.func = FUNC_READ;
    b.x_pos = 16'(near_x());
    b.y_pos = 16'(near_y());
    return b;
  endfunction

  // mostly small rectangles; a few keep full-range sizes
  function automatic in_beat_t make_fill();
    in_beat_t b;
    b = noise_beat();
    b.func = FUNC_FILL;
    b.x_pos = 16'(near_x());
    b.y_pos = 16'(near_y());
    if (big_fills < 3 && $urandom_range(0, 99) < 2) begin
      big_fills++;
    end else begin
      b.width = 12'($urandom_range(0, 20));
      b.height = 12'($urandom_range(0, 20));
    end
    return b;
  endfunction

  function automatic in_beat_t side_beat();
    if ($urandom_range(0, 1) == 0) return make_read();
    return make_fill();
  endfunction

  task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
    read_key_t key;
    key.typed = typed;
    key.want = want;
    read_keys.push_back(key);
    in_beat <= b;
    in_valid <= 1'b1;
    sent++;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_cmd(input in_beat_t b);
    send_beat(b, 1'b0, '0);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(0, 8);
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (in_taken != sent || due_pixels.size() != 0);
  endtask

  always @(posedge clk) begin : scoreboard
    out_beat_t want;
    out_beat_t pred;
    read_key_t key;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_pixels.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time,
                   out_beat);
          errors++;
        end else begin
          want = due_pixels.pop_front();
          if (out_beat.pixel_value !== want.pixel_value) begin
            $display("%0t: pixel_value mismatch, expected %h, got %h", $time,
                     want.pixel_value, out_beat.pixel_value);
            errors++;
          end
          if (out_beat.on_screen !== want.on_screen) begin
            $display("%0t: on_screen mismatch, expected %b, got %b", $time,
                     want.on_screen, out_beat.on_screen);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        key = read_keys.pop_front();
        if (render_command(in_beat, pred))
          due_pixels.push_back(key.typed ? key.want : pred);
        in_taken++;
      end
    end
  end

  initial begin : receiver
    stall_mode_t mode;
    int span, k;
    forever begin
      if (hold_asks != hold_served) begin
        for (k = 0; k < HOLD_CYCLES; k++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_served++;
      end else begin
        mode = stall_mode_t'($urandom_range(0, 3));
        span = $urandom_range(10, 80);
        for (k = 0; k < span; k++) begin
          if (hold_asks != hold_served) break;
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((k % 6) < 2);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: watchdog expired", $time);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    in_beat_t b;
    int k, n, pick, sel, w, h, total;
    bit did_hold, did_pause;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_beat <= '0;
    did_hold = 1'b0;
    did_pause = 1'b0;

    // reads straight after the clear pass, in and out of the screen
    add_row(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 1'b1, 'h0000, 1'b1);
    add_row(FUNC_READ, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 4095, 4095, 'hFFFF, 'hFFFF,
            'hFFFF, 1'b1, 'h0000, 1'b1);
    add_row(FUNC_READ, -32768, -32768, 0, 0, 0, 0, 0, 1'b1, 'h0000, 1'b0);
    add_row(FUNC_READ, 32767, 32767, 0, 0, 0, 0, 0, 1'b1, 'h0000, 1'b0);
    add_row(FUNC_READ, SCREEN_WIDTH, SCREEN_HEIGHT - 1, 0, 0, 0, 0, 0, 1'b1, 'h0000, 1'b0);
    // whole screen, then rectangles clipped to nothing, clipped in part, empty
    add_row(FUNC_FILL, 0, 0, 4095, 4095, 'hFFFF, 0, 0);
    add_row(FUNC_READ, SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1, 0, 0, 0, 0, 0, 1'b1, 'hFFFF,
            1'b1);
    add_row(FUNC_FILL, -32768, -32768, 4095, 4095, 'h0000, 0, 0);
    add_row(FUNC_FILL, -5, -5, 10, 10, 'h1234, 0, 0);
    add_row(FUNC_FILL, 10, 10, 0, 7, 'h0000, 0, 0);
    // bitmap across the right edge, a read between bytes, then overrun
    add_row(FUNC_BMP_START, SCREEN_WIDTH - 4, 2, 10, 1, 'hF800, 'h07E0, 0);
    add_row(FUNC_BMP_BYTE, 0, 0, 0, 0, 0, 0, 'hFFA5);
    add_row(FUNC_READ, SCREEN_WIDTH - 3, 2, 0, 0, 0, 0, 0);
    add_row(FUNC_BMP_BYTE, 0, 0, 0, 0, 0, 0, 'h0081);
    add_row(FUNC_BMP_BYTE, 0, 0, 0, 0, 0, 0, 'h5555);
    // line across the left edge with one pixel past its width
    add_row(FUNC_LINE_START, -2, 100, 3, 0, 0, 0, 0);
    add_row(FUNC_LINE_PIX, 0, 0, 0, 0, 0, 0, 'hAAAA);
    add_row(FUNC_LINE_PIX, 0, 0, 0, 0, 0, 0, 'h5555);
    add_row(FUNC_LINE_PIX, 0, 0, 0, 0, 0, 0, 'hC3C3);
    add_row(FUNC_LINE_PIX, 0, 0, 0, 0, 0, 0, 'h0001);
    add_row(FUNC_BMP_BYTE, 0, 0, 0, 0, 0, 0, 'h00FF);
    add_row(FUNC_SPARE_A, 5, 5, 5, 5, 'hFFFF, 'hFFFF, 'hFFFF);
    add_row(FUNC_SPARE_B, 6, 6, 6, 6, 'hFFFF, 'hFFFF, 'hFFFF);
    // empty bitmap swallows data; a line pixel with no line open is dropped
    add_row(FUNC_BMP_START, 0, 0, 0, 3, 'hFFFF, 'hFFFF, 0);
    add_row(FUNC_BMP_BYTE, 0, 0, 0, 0, 0, 0, 'h00FF);
    add_row(FUNC_LINE_PIX, 0, 0, 0, 0, 0, 0, 'hBEEF);
    add_row(FUNC_READ, 0, 100, 0, 0, 0, 0, 0);
    add_row(FUNC_READ, SCREEN_WIDTH - 4, 2, 0, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      send_beat(dir_table[i].beat, dir_table[i].typed, dir_table[i].want);
      pace_sender();
    end
    wait_drained();

    total = dir_table.size() + RANDOM_ITEMS;
    while (sent < total) begin
      if (!did_hold && sent > dir_table.size() + 400) begin
        did_hold = 1'b1;
        hold_asks++;
        for (k = 0; k < HOLD_READS; k++) send_cmd(make_read());
      end
      if (!did_pause && sent > dir_table.size() + 800) begin
        did_pause = 1'b1;
        wait_drained();
      end
      pick = $urandom_range(0, 99);
      if (pick < 22 || (pick >= 22 && pick < 36)) begin
        b = noise_beat();
        b.func = (pick < 22) ? FUNC_BMP_START : FUNC_LINE_START;
        b.x_pos = 16'(near_x());
        b.y_pos = 16'(near_y());
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          b.width = '0;
        end else if (sel != 1) begin
          b.width = 12'((pick < 22) ? $urandom_range(1, 20) : $urandom_range(1, 30));
        end
        if (sel == 2) b.height = '0;
        else if (sel != 1) b.height = 12'($urandom_range(1, 5));
        w = int'(b.width);
        h = int'(b.height);
        send_cmd(b);
        pace_sender();
        n = ((pick < 22) ? ((w + 7) / 8) * h : w) + $urandom_range(0, 2);
        if (n > 40) n = 40;
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_cmd(side_beat());
            pace_sender();
          end
          b = noise_beat();
          b.func = (pick < 22) ? FUNC_BMP_BYTE : FUNC_LINE_PIX;
          send_cmd(b);
          pace_sender();
        end
      end else if (pick < 50) begin
        send_cmd(make_fill());
        pace_sender();
      end else if (pick < 80) begin
        send_cmd(make_read());
        pace_sender();
      end else if (pick < 90) begin
        b = noise_beat();
        b.func = $urandom_range(0, 1) ? FUNC_BMP_BYTE : FUNC_LINE_PIX;
        send_cmd(b);
        pace_sender();
      end else if (pick < 94) begin
        b = noise_beat();
        b.func = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
        send_cmd(b);
        pace_sender();
      end else begin
        n = $urandom_range(3, 8);
        for (k = 0; k < n; k++) begin
          send_cmd(make_read());
          pace_sender();
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && due_pixels.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> clipped_framebuffer_draw_engine.f
design/cfde_pkg.sv
design/cfde_fb_ram.sv
design/cfde_seq.sv
design/clipped_framebuffer_draw_engine.sv
tb/sv/clipped_framebuffer_draw_engine_test.sv
